// ===== hdl/fcp_pkg.sv =====
// fly camera pose update: shared types, codes and constants
// no dependencies; used by the top level
`default_nettype none

package fcp_pkg;

    // item codes
    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_PITCH = 2'd1,
        ACT_YAW   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        DIR_NONE    = 3'd0,
        DIR_LEFT    = 3'd1,
        DIR_RIGHT   = 3'd2,
        DIR_FORWARD = 3'd3,
        DIR_BACK    = 3'd4
    } move_dir_t;

    // datapath word for cordic, axis, matrix and difference values
    localparam int DW = 34;
    typedef logic signed [DW-1:0] word_t;

    localparam logic [4:0] AXIS_BITS = 5'd28;
    localparam word_t ONE_Q28     = 34'sh0_1000_0000;
    localparam word_t HALF_PI_Q30 = 34'sd1686629713;
    localparam word_t PI_Q30      = 34'sd3373259426;
    localparam word_t CORDIC_GAIN = 34'sh0_26DD_3B6A;

    // arctan(2^-i) in Q30
    localparam logic [29:0] ATAN_TAB [24] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    // operand pairs for the axis products xx, xy, xz, yy, yz, zz
    localparam logic [1:0] PAIR_A [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] PAIR_B [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -48'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/fcp_if.sv =====
// fly camera pose update: valid/ready channel interfaces
// depends on nothing; payload widths follow the item and result fields
`default_nettype none

interface fcp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [2:0]         move_dir;
    logic [15:0]        delta_time;
    logic signed [15:0] angle;

    modport source (output valid, action, move_dir, delta_time, angle, input ready);
    modport sink   (input valid, action, move_dir, delta_time, angle, output ready);
endinterface

interface fcp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               degenerate;

    modport source (output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
                    degenerate, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
                    degenerate, output ready);
endinterface

interface fcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] move_speed;

    modport source (output valid, move_speed, input ready);
    modport sink   (input valid, move_speed, output ready);
endinterface

`default_nettype wire

// ===== hdl/fly_camera_pose_update.sv =====
// fly camera pose update: top level, sequencer around one shared multiplier
// depends on fcp_pkg and the channel interfaces in fcp_if.sv
//
// usage: item_in carries one action (move, pitch or yaw) per item; result_out
// returns one item per input with the pose after it and a degenerate flag.
// cfg writes the move speed (unsigned q16.8) at any edge with cfg.valid high;
// cfg.ready is always high and writes belong between items.
// one item at a time: item_in.ready is high only while the sequencer is idle.
// each item walks through the sequencer: a move or a pitch normalises a vector
// with the bit-serial square root (32 steps) and the restoring divider (one
// quotient bit a cycle for each of three components); a pitch or a yaw runs the
// cordic (one micro-rotation a cycle) and builds the rotation matrix; the single
// multiplier is used for every product. no move or an unknown action goes
// straight to the result; a zero vector to normalise sets the degenerate flag.
// reset puts position at the origin, target at (0,0,-1) and speed at 1.0.
// a finished result waits in the output register; the next item is accepted
// meanwhile, and its result is held back until the receiver takes the first.
`default_nettype none

module fly_camera_pose_update #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire          clk,
    input  wire          rst_n,
    fcp_in_if.sink       item_in,
    fcp_out_if.source    result_out,
    fcp_cfg_if.sink      cfg
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIFF, S_NLOAD, S_NSHIFT, S_NSQ, S_NSQRT, S_NDIV,
        S_DIST, S_MVHI, S_MVLO, S_MVAPPLY,
        S_CINIT, S_CORDIC, S_CFIN, S_PROD, S_MAT, S_MAC, S_FINISH
    } state_t;

    state_t state_reg;

    // item and pose
    logic [1:0]           act_reg;
    logic [2:0]           dir_reg;
    logic [15:0]          dt_reg;
    logic signed [15:0]   ang_reg;
    logic [23:0]          speed_reg;
    logic signed [31:0]   pos_reg [3];
    logic signed [31:0]   tgt_reg [3];
    logic                 deg_reg;

    // normalisation
    fcp_pkg::word_t       d_reg [3];
    logic                 use_rv_reg;
    logic [4:0]           fb_reg;
    logic [32:0]          mag_reg [3];
    logic                 neg_reg [3];
    logic [32:0]          mx_reg;
    logic [1:0]           idx_reg;
    logic [61:0]          sum_reg;
    logic [63:0]          sq_v_reg;
    logic [63:0]          sq_r_reg;
    logic [4:0]           sq_cnt_reg;
    logic [31:0]          len_reg;
    logic [32:0]          rem_reg;
    logic [4:0]           div_cnt_reg;
    logic [28:0]          q_reg [3];

    // move
    logic [39:0]          dist_reg;
    logic [40:0]          ph_reg;
    logic [41:0]          stepmag_reg;

    // rotation
    fcp_pkg::word_t       axis_reg [3];
    fcp_pkg::word_t       cx_reg, cy_reg, cz_reg;
    logic                 flip_reg;
    logic [4:0]           cr_cnt_reg;
    fcp_pkg::word_t       cs_reg, sn_reg, omc_reg;
    fcp_pkg::word_t       t_reg [6];
    fcp_pkg::word_t       sp_reg [3];
    fcp_pkg::word_t       m_reg [9];
    logic [3:0]           stp_reg;
    logic [1:0]           row_reg;
    logic [1:0]           k_reg;
    logic signed [67:0]   acc_reg;

    // result register
    logic                 res_valid_reg;
    logic signed [31:0]   res_pos_reg [3];
    logic signed [31:0]   res_tgt_reg [3];
    logic                 res_deg_reg;

    // shared multiplier
    fcp_pkg::word_t       mul_a, mul_b;
    logic signed [67:0]   mul_p;
    fcp_pkg::word_t       mul_q28;

    // combinational helpers
    fcp_pkg::word_t       vec [3];
    logic [32:0]          vabs [3];
    logic [32:0]          vmax;
    logic [63:0]          sq_bit, sq_rb, sq_r_next, sq_v_next;
    logic                 sq_ge;
    logic                 div_ge;
    logic [32:0]          div_rem;
    fcp_pkg::word_t       sh_x, sh_y, atan_w;
    fcp_pkg::word_t       theta, fx, fy;
    logic [1:0]           k_sel;
    logic [3:0]           m_idx;
    logic [2:0]           t_idx;
    logic [1:0]           s_idx;
    logic                 minus;
    logic signed [43:0]   mv_step;
    logic signed [31:0]   mv_pos, mv_tgt, mac_tgt;
    logic                 out_free;

    assign mul_p   = mul_a * mul_b;
    assign mul_q28 = mul_p[61:28];

    assign k_sel = (k_reg == 2'd3) ? 2'd0 : k_reg;
    assign m_idx = ({2'b00, row_reg} << 1) + {2'b00, row_reg} + {2'b00, k_sel};
    assign t_idx = (stp_reg < 4'd6) ? stp_reg[2:0] : 3'(stp_reg - 4'd6);
    assign s_idx = 2'(4'd14 - stp_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NSQ:
            begin
                mul_a = {1'b0, mag_reg[idx_reg]};
                mul_b = {1'b0, mag_reg[idx_reg]};
            end
            S_DIST:
            begin
                mul_a = {18'd0, dt_reg};
                mul_b = {10'd0, speed_reg};
            end
            S_MVHI:
            begin
                mul_a = {5'd0, q_reg[idx_reg]};
                mul_b = {18'd0, dist_reg[39:24]};
            end
            S_MVLO:
            begin
                mul_a = {5'd0, q_reg[idx_reg]};
                mul_b = {10'd0, dist_reg[23:0]};
            end
            S_PROD:
            begin
                if (stp_reg < 4'd6)
                begin
                    mul_a = axis_reg[fcp_pkg::PAIR_A[t_idx]];
                    mul_b = axis_reg[fcp_pkg::PAIR_B[t_idx]];
                end
                else if (stp_reg < 4'd12)
                begin
                    mul_a = t_reg[t_idx];
                    mul_b = omc_reg;
                end
                else
                begin
                    mul_a = axis_reg[s_idx];
                    mul_b = sn_reg;
                end
            end
            S_MAC:
            begin
                mul_a = m_reg[m_idx];
                mul_b = d_reg[k_sel];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // vector to normalise: right axis (-dz, 0, dx) or forward d
    always_comb
    begin
        if (use_rv_reg)
        begin
            vec[0] = -d_reg[2];
            vec[1] = '0;
            vec[2] = d_reg[0];
        end
        else
        begin
            vec[0] = d_reg[0];
            vec[1] = d_reg[1];
            vec[2] = d_reg[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            vabs[i] = vec[i][33] ? 33'(-vec[i]) : vec[i][32:0];
        end
        vmax = vabs[0];
        if (vabs[1] > vmax)
            vmax = vabs[1];
        if (vabs[2] > vmax)
            vmax = vabs[2];
    end

    // one square root step
    always_comb
    begin
        sq_bit    = 64'd1 << (6'd62 - {sq_cnt_reg, 1'b0});
        sq_rb     = sq_r_reg + sq_bit;
        sq_ge     = sq_v_reg >= sq_rb;
        sq_r_next = sq_ge ? ((sq_r_reg >> 1) + sq_bit) : (sq_r_reg >> 1);
        sq_v_next = sq_ge ? (sq_v_reg - sq_rb) : sq_v_reg;
    end

    // one restoring division step
    assign div_ge  = rem_reg >= {1'b0, len_reg};
    assign div_rem = div_ge ? (rem_reg - {1'b0, len_reg}) : rem_reg;

    // cordic micro-rotation operands
    assign sh_x   = cx_reg >>> cr_cnt_reg;
    assign sh_y   = cy_reg >>> cr_cnt_reg;
    assign atan_w = $signed({4'd0, fcp_pkg::ATAN_TAB[cr_cnt_reg]});
    assign theta  = {ang_reg[15], ang_reg, 17'd0};
    assign fx     = flip_reg ? -cx_reg : cx_reg;
    assign fy     = flip_reg ? -cy_reg : cy_reg;

    // move step with sign and saturation
    assign minus   = (dir_reg == fcp_pkg::DIR_LEFT) || (dir_reg == fcp_pkg::DIR_BACK);
    assign mv_step = (neg_reg[idx_reg] != minus) ? -$signed({2'b00, stepmag_reg})
                                                 : $signed({2'b00, stepmag_reg});
    assign mv_pos  = fcp_pkg::sat32(48'(pos_reg[idx_reg]) + 48'(mv_step));
    assign mv_tgt  = fcp_pkg::sat32(48'(tgt_reg[idx_reg]) + 48'(mv_step));
    assign mac_tgt = fcp_pkg::sat32(48'(pos_reg[row_reg]) + 48'($signed(acc_reg[67:28])));

    assign out_free = !res_valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            speed_reg     <= 24'd256;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            tgt_reg[2]    <= -(32'sd1 <<< FRAC_BITS);
        end
        else
        begin
            if (cfg.valid)
                speed_reg <= cfg.move_speed;
            if (res_valid_reg && result_out.ready && !(state_reg == S_FINISH && out_free))
                res_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_in.valid)
                    begin
                        act_reg   <= item_in.action;
                        dir_reg   <= item_in.move_dir;
                        dt_reg    <= item_in.delta_time;
                        ang_reg   <= item_in.angle;
                        deg_reg   <= 1'b0;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        d_reg[i] <= 34'(tgt_reg[i]) - 34'(pos_reg[i]);
                    end
                    if (act_reg == fcp_pkg::ACT_MOVE && dir_reg >= fcp_pkg::DIR_LEFT &&
                        dir_reg <= fcp_pkg::DIR_BACK)
                    begin
                        use_rv_reg <= dir_reg <= fcp_pkg::DIR_RIGHT;
                        fb_reg     <= 5'(FRAC_BITS);
                        state_reg  <= S_NLOAD;
                    end
                    else if (act_reg == fcp_pkg::ACT_PITCH)
                    begin
                        use_rv_reg <= 1'b1;
                        fb_reg     <= fcp_pkg::AXIS_BITS;
                        state_reg  <= S_NLOAD;
                    end
                    else if (act_reg == fcp_pkg::ACT_YAW)
                        state_reg <= S_CINIT;
                    else
                        state_reg <= S_FINISH;
                end
                S_NLOAD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= vabs[i];
                        neg_reg[i] <= vec[i][33];
                    end
                    mx_reg <= vmax;
                    if (vmax == 33'd0)
                    begin
                        deg_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                        state_reg <= S_NSHIFT;
                end
                S_NSHIFT:
                begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (mx_reg[32:29] == 4'd0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                        mx_reg <= mx_reg << 1;
                    end
                    else if (mx_reg[32:30] != 3'd0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                        mx_reg <= mx_reg >> 1;
                    end
                    else
                    begin
                        idx_reg   <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= S_NSQ;
                    end
                end
                S_NSQ:
                begin
                    sum_reg <= sum_reg + mul_p[61:0];
                    if (idx_reg == 2'd2)
                    begin
                        sq_v_reg   <= {2'b00, sum_reg + mul_p[61:0]};
                        sq_r_reg   <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= S_NSQRT;
                    end
                    else
                        idx_reg <= idx_reg + 2'd1;
                end
                S_NSQRT:
                begin
                    sq_v_reg   <= sq_v_next;
                    sq_r_reg   <= sq_r_next;
                    sq_cnt_reg <= sq_cnt_reg + 5'd1;
                    if (sq_cnt_reg == 5'd31)
                    begin
                        len_reg     <= sq_r_next[31:0];
                        idx_reg     <= 2'd0;
                        rem_reg     <= mag_reg[0];
                        div_cnt_reg <= fb_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            q_reg[i] <= '0;
                        end
                        state_reg   <= S_NDIV;
                    end
                end
                S_NDIV:
                begin
                    q_reg[idx_reg] <= {q_reg[idx_reg][27:0], div_ge};
                    if (div_cnt_reg == 5'd0)
                    begin
                        div_cnt_reg <= fb_reg;
                        if (idx_reg == 2'd2)
                        begin
                            idx_reg   <= 2'd0;
                            state_reg <= (act_reg == fcp_pkg::ACT_MOVE) ? S_DIST : S_CINIT;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                            rem_reg <= mag_reg[idx_reg + 2'd1];
                        end
                    end
                    else
                    begin
                        rem_reg     <= {div_rem[31:0], 1'b0};
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                    end
                end
                S_DIST:
                begin
                    dist_reg  <= mul_p[39:0];
                    idx_reg   <= 2'd0;
                    state_reg <= S_MVHI;
                end
                S_MVHI:
                begin
                    ph_reg    <= mul_p[40:0];
                    state_reg <= S_MVLO;
                end
                S_MVLO:
                begin
                    stepmag_reg <= {1'b0, ph_reg} + {17'd0, mul_p[48:24]};
                    state_reg   <= S_MVAPPLY;
                end
                S_MVAPPLY:
                begin
                    pos_reg[idx_reg] <= mv_pos;
                    tgt_reg[idx_reg] <= mv_tgt;
                    if (idx_reg == 2'd2)
                        state_reg <= S_FINISH;
                    else
                    begin
                        idx_reg   <= idx_reg + 2'd1;
                        state_reg <= S_MVHI;
                    end
                end
                S_CINIT:
                begin
                    if (act_reg == fcp_pkg::ACT_PITCH)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            axis_reg[i] <= neg_reg[i] ? -$signed({5'd0, q_reg[i]})
                                                      : $signed({5'd0, q_reg[i]});
                        end
                    end
                    else
                    begin
                        axis_reg[0] <= '0;
                        axis_reg[1] <= fcp_pkg::ONE_Q28;
                        axis_reg[2] <= '0;
                    end
                    // fold the angle into [-pi/2, pi/2]
                    if (theta > fcp_pkg::HALF_PI_Q30)
                    begin
                        cz_reg   <= theta - fcp_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end
                    else if (theta < -fcp_pkg::HALF_PI_Q30)
                    begin
                        cz_reg   <= theta + fcp_pkg::PI_Q30;
                        flip_reg <= 1'b1;
                    end
                    else
                    begin
                        cz_reg   <= theta;
                        flip_reg <= 1'b0;
                    end
                    cx_reg     <= fcp_pkg::CORDIC_GAIN;
                    cy_reg     <= '0;
                    cr_cnt_reg <= '0;
                    state_reg  <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - sh_y;
                        cy_reg <= cy_reg + sh_x;
                        cz_reg <= cz_reg - atan_w;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + sh_y;
                        cy_reg <= cy_reg - sh_x;
                        cz_reg <= cz_reg + atan_w;
                    end
                    cr_cnt_reg <= cr_cnt_reg + 5'd1;
                    if (cr_cnt_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= S_CFIN;
                end
                S_CFIN:
                begin
                    cs_reg    <= fx >>> 2;
                    sn_reg    <= fy >>> 2;
                    omc_reg   <= fcp_pkg::ONE_Q28 - (fx >>> 2);
                    stp_reg   <= '0;
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    // axis pair products, then times (1 - cos), then axis times sin
                    if (stp_reg < 4'd12)
                        t_reg[t_idx] <= mul_q28;
                    else
                        sp_reg[s_idx] <= mul_q28;
                    stp_reg <= stp_reg + 4'd1;
                    if (stp_reg == 4'd14)
                        state_reg <= S_MAT;
                end
                S_MAT:
                begin
                    m_reg[0]  <= cs_reg + t_reg[0];
                    m_reg[1]  <= t_reg[1] - sp_reg[2];
                    m_reg[2]  <= t_reg[2] + sp_reg[1];
                    m_reg[3]  <= t_reg[1] + sp_reg[2];
                    m_reg[4]  <= cs_reg + t_reg[3];
                    m_reg[5]  <= t_reg[4] - sp_reg[0];
                    m_reg[6]  <= t_reg[2] - sp_reg[1];
                    m_reg[7]  <= t_reg[4] + sp_reg[0];
                    m_reg[8]  <= cs_reg + t_reg[5];
                    row_reg   <= '0;
                    k_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (k_reg != 2'd3)
                    begin
                        acc_reg <= acc_reg + mul_p;
                        k_reg   <= k_reg + 2'd1;
                    end
                    else
                    begin
                        tgt_reg[row_reg] <= mac_tgt;
                        acc_reg          <= '0;
                        k_reg            <= '0;
                        if (row_reg == 2'd2)
                            state_reg <= S_FINISH;
                        else
                            row_reg <= row_reg + 2'd1;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_pos_reg   <= pos_reg;
                        res_tgt_reg   <= tgt_reg;
                        res_deg_reg   <= deg_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign item_in.ready         = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign result_out.valid      = res_valid_reg;
    assign result_out.pos_x      = res_pos_reg[0];
    assign result_out.pos_y      = res_pos_reg[1];
    assign result_out.pos_z      = res_pos_reg[2];
    assign result_out.target_x   = res_tgt_reg[0];
    assign result_out.target_y   = res_tgt_reg[1];
    assign result_out.target_z   = res_tgt_reg[2];
    assign result_out.degenerate = res_deg_reg;

    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> !item_in.ready)
        else $error("item accepted while another is in flight");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NSQ) |-> (mx_reg[32:30] == 3'd0 && mx_reg[29]))
        else $error("normalised magnitude out of range");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NDIV) |-> (len_reg[31:29] != 3'd0))
        else $error("square root below divisor range");

    a_pos_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |=> $stable({pos_reg[0], pos_reg[1], pos_reg[2]}))
        else $error("position changed during rotation");

    a_cordic_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CORDIC) |-> (cr_cnt_reg < 5'(CORDIC_STEPS)))
        else $error("cordic step count overrun");

endmodule

`default_nettype wire
